// ----- design/fpff_pkg.sv -----
// ----------------------------------------------------------------------------
// fpff_pkg
// Shared types and constants of the fixed-partition first-fit allocator.
// ----------------------------------------------------------------------------
package fpff_pkg;

  localparam int MAX_PARTITIONS = 16;
  localparam int SLOT_W         = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
  localparam int CNT_W          = $clog2(MAX_PARTITIONS + 1);
  localparam int SIZE_W         = 20;
  localparam int FRAG_W         = 24;
  localparam int SLOT_OUT_W     = 4;
  localparam int FIFO_DEPTH     = 2;
  localparam int FIFO_AW        = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FIFO_CW        = $clog2(FIFO_DEPTH + 1);

  localparam logic OP_DEFINE = 1'b0;
  localparam logic OP_ALLOC  = 1'b1;

  typedef enum logic [2:0] {
    ST_ACCEPTED   = 3'd0,
    ST_REJECTED   = 3'd1,
    ST_PLACED     = 3'd2,
    ST_NONE_LEFT  = 3'd3,
    ST_NONE_FITS  = 3'd4,
    ST_TABLE_FULL = 3'd5
  } status_e;

  typedef enum logic {
    CMD_DEFINE,
    CMD_ALLOC
  } cmd_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DEFINE,
    BK_SCAN
  } bk_state_e;

  typedef struct packed {
    logic              opcode;
    logic [SIZE_W-1:0] item_size;
  } in_t;

  typedef struct packed {
    status_e               status;
    logic [SLOT_OUT_W-1:0] slot;
    logic [SIZE_W-1:0]     space_left;
    logic [FRAG_W-1:0]     fragmentation;
  } out_t;

  typedef struct packed {
    cmd_e              kind;
    logic [SIZE_W-1:0] size;
  } cmd_t;

  // Queue write side and queue head.
  typedef struct packed {
    logic push;
    cmd_t cmd;
  } q_wr_t;

  typedef struct packed {
    logic avail;
    cmd_t cmd;
  } q_rd_t;

endpackage

// ----- design/fpff_front.sv -----
// ----------------------------------------------------------------------------
// fpff_front
// Input stage: registers one beat, decodes its opcode and hands it to the queue.
// ----------------------------------------------------------------------------
module fpff_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  fpff_pkg::in_t   in_data_i,
  input  logic            q_full_i,
  output fpff_pkg::q_wr_t q_wr_o
);
  import fpff_pkg::*;

  logic valid_q, valid_d;
  cmd_t cmd_q;
  logic accept;
  logic push;

  assign in_stall_o = valid_q && q_full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign push       = valid_q && !q_full_i;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (push) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q.kind <= (in_data_i.opcode == OP_ALLOC) ? CMD_ALLOC : CMD_DEFINE;
      cmd_q.size <= in_data_i.item_size;
    end
  end

  assign q_wr_o.push = push;
  assign q_wr_o.cmd  = cmd_q;

endmodule

// ----- design/fpff_fifo.sv -----
// ----------------------------------------------------------------------------
// fpff_fifo
// Short command queue between the decode stage and the execution engine.
// ----------------------------------------------------------------------------
module fpff_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  fpff_pkg::q_wr_t wr_i,
  output logic            full_o,
  input  logic            pop_i,
  output fpff_pkg::q_rd_t head_o
);
  import fpff_pkg::*;

  cmd_t               mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_CW-1:0] cnt_q, cnt_d;
  logic               push;
  logic               pop;

  assign full_o = (cnt_q == FIFO_CW'(FIFO_DEPTH));
  assign push   = wr_i.push && !full_o;
  assign pop    = pop_i && (cnt_q != '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_i.cmd;
    end
  end

  assign head_o.avail = (cnt_q != '0);
  assign head_o.cmd   = mem_q[rd_ptr_q];

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FIFO_CW'(FIFO_DEPTH))
    else $error("queue count beyond depth");
`endif

endmodule

// ----- design/fpff_back.sv -----
// ----------------------------------------------------------------------------
// fpff_back
// Execution engine: partition table, first-fit scan and result register.
// ----------------------------------------------------------------------------
module fpff_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  input  logic [fpff_pkg::SIZE_W-1:0] cfg_data_i,
  input  fpff_pkg::q_rd_t             head_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output fpff_pkg::out_t              out_data_o
);
  import fpff_pkg::*;

  bk_state_e             state_q, state_d;
  cmd_t                  cmd_q;
  logic [CNT_W-1:0]      scan_idx_q, scan_idx_d;
  logic [SIZE_W-1:0]     size_mem [MAX_PARTITIONS];
  logic [SIZE_W-1:0]     rdata_q;
  logic [MAX_PARTITIONS-1:0] usable_q;
  logic [CNT_W-1:0]      slots_q;
  logic [CNT_W-1:0]      open_q;
  logic [SIZE_W-1:0]     used_q;
  logic [FRAG_W-1:0]     frag_q;
  logic [SIZE_W-1:0]     total_q;
  logic                  out_valid_q;
  status_e               out_status_q;
  logic [SLOT_OUT_W-1:0] out_slot_q;

  logic                  out_free;
  logic [SLOT_W-1:0]     def_slot;
  logic [SLOT_W-1:0]     scan_slot;
  logic                  table_full;
  logic [SIZE_W:0]       used_sum;
  logic                  fits;
  logic                  none_left;
  logic                  scan_end;
  logic                  hit;
  logic [SIZE_W-1:0]     left;
  logic [FRAG_W:0]       frag_sum;
  logic                  def_commit;
  logic                  place_commit;
  logic                  load;
  status_e               res_status;
  logic [SLOT_OUT_W-1:0] res_slot;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign def_slot   = slots_q[SLOT_W-1:0];
  assign scan_slot  = scan_idx_q[SLOT_W-1:0];
  assign table_full = (slots_q == CNT_W'(MAX_PARTITIONS));
  assign used_sum   = {1'b0, used_q} + {1'b0, cmd_q.size};
  assign fits       = (used_sum <= {1'b0, total_q});
  assign none_left  = (open_q == '0);
  assign scan_end   = (scan_idx_q >= slots_q);
  assign hit        = usable_q[scan_slot] && (rdata_q >= cmd_q.size);
  assign left       = rdata_q - cmd_q.size;
  assign frag_sum   = {1'b0, frag_q} + {{(FRAG_W - SIZE_W + 1){1'b0}}, left};

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (head_i.avail) begin
          state_d = (head_i.cmd.kind == CMD_ALLOC) ? BK_SCAN : BK_DEFINE;
        end
      end
      BK_DEFINE: begin
        if (out_free) begin
          state_d = BK_IDLE;
        end
      end
      BK_SCAN: begin
        if (out_free && (none_left || scan_end || hit)) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    pop_o        = 1'b0;
    scan_idx_d   = scan_idx_q;
    def_commit   = 1'b0;
    place_commit = 1'b0;
    load         = 1'b0;
    res_status   = ST_ACCEPTED;
    res_slot     = '0;
    unique case (state_q)
      BK_IDLE: begin
        pop_o      = head_i.avail;
        scan_idx_d = '0;
      end
      BK_DEFINE: begin
        load = out_free;
        if (table_full) begin
          res_status = ST_TABLE_FULL;
        end else begin
          def_commit = out_free;
          res_slot   = SLOT_OUT_W'(def_slot);
          res_status = fits ? ST_ACCEPTED : ST_REJECTED;
        end
      end
      BK_SCAN: begin
        priority if (none_left) begin
          res_status = ST_NONE_LEFT;
          load       = out_free;
        end else if (scan_end) begin
          res_status = ST_NONE_FITS;
          load       = out_free;
        end else if (hit) begin
          res_status   = ST_PLACED;
          res_slot     = SLOT_OUT_W'(scan_slot);
          load         = out_free;
          place_commit = out_free;
        end else begin
          // advance to the next slot
          scan_idx_d = scan_idx_q + 1'b1;
        end
      end
      default: begin
        scan_idx_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      scan_idx_q  <= '0;
      usable_q    <= '0;
      slots_q     <= '0;
      open_q      <= '0;
      used_q      <= '0;
      frag_q      <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      scan_idx_q <= scan_idx_d;
      if (cfg_valid_i) begin
        total_q <= cfg_data_i;
      end
      if (def_commit) begin
        usable_q[def_slot] <= fits;
        slots_q            <= slots_q + 1'b1;
        if (fits) begin
          used_q <= used_sum[SIZE_W-1:0];
          open_q <= open_q + 1'b1;
        end
      end
      if (place_commit) begin
        usable_q[scan_slot] <= 1'b0;
        open_q              <= open_q - 1'b1;
        frag_q              <= frag_sum[FRAG_W] ? '1 : frag_sum[FRAG_W-1:0];
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cmd_q <= head_i.cmd;
    end
    if (load) begin
      out_status_q <= res_status;
      out_slot_q   <= res_slot;
    end
  end

  // Partition size table, registered read one slot ahead of the compare
  always_ff @(posedge clk_i) begin
    if (def_commit && fits) begin
      size_mem[def_slot] <= cmd_q.size;
    end
    rdata_q <= size_mem[scan_idx_d[SLOT_W-1:0]];
  end

  assign out_valid_o              = out_valid_q;
  assign out_data_o.status        = out_status_q;
  assign out_data_o.slot          = out_slot_q;
  assign out_data_o.space_left    = (used_q > total_q) ? '0 : total_q - used_q;
  assign out_data_o.fragmentation = frag_q;

`ifndef SYNTH
  a_open_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q == $countones(usable_q))
    else $error("open partition count disagrees with usable flags");

  a_place_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    place_commit |=> ($countones(usable_q) + 1 == $countones($past(usable_q))))
    else $error("placement did not retire exactly one partition");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_SCAN) |-> (scan_idx_q <= slots_q))
    else $error("scan ran past the defined slots");

  a_slots_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slots_q <= CNT_W'(MAX_PARTITIONS))
    else $error("slot count beyond table size");
`endif

endmodule

// ----- design/fixed_partition_first_fit.sv -----
// ----------------------------------------------------------------------------
// fixed_partition_first_fit
// Fixed-partition first-fit allocator: decode stage, command queue, engine.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  (in_valid_i / in_stall_o / in_data_i): opcode 0 defines the
//     next partition, opcode 1 allocates a process by first fit.
//   out channel (out_valid_o / out_stall_i / out_data_o): one result beat per
//     input beat, in order: status, slot, space left and fragmentation total.
//   cfg channel (cfg_valid_i / cfg_ready_o / cfg_data_i): total memory size,
//     always ready; write it only while no item is in flight.
// Flow: the decode stage registers each accepted beat and pushes it into the
//   queue; the engine pops it, a define then loads its result register, and an
//   allocate walks the table one slot per cycle through a registered read of
//   the size table until a slot fits or the defined slots run out. The engine
//   takes one command at a time; a two-entry queue lets the decode stage keep
//   taking beats meanwhile.
// Reset empties the table, clears all totals and the size register.
// A stalled result holds in the output register; the engine then waits and
//   the queue fills, after which in_stall_o rises.
// ----------------------------------------------------------------------------
module fixed_partition_first_fit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  fpff_pkg::in_t               in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output fpff_pkg::out_t              out_data_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [fpff_pkg::SIZE_W-1:0] cfg_data_i
);
  import fpff_pkg::*;

  q_wr_t q_wr;
  q_rd_t q_head;
  logic  q_full;
  logic  q_pop;

  assign cfg_ready_o = 1'b1;

  fpff_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .q_wr_o     (q_wr)
  );

  fpff_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (q_wr),
    .full_o (q_full),
    .pop_i  (q_pop),
    .head_o (q_head)
  );

  fpff_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .head_i      (q_head),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- tb/fpff_checker.sv -----
// ----------------------------------------------------------------------------
// fpff_checker
// Watches the input, result and size channels of the first-fit allocator,
// keeps its own partition table, and checks every result beat field by field.
// ----------------------------------------------------------------------------
module fpff_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  fpff_pkg::in_t               in_data_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  fpff_pkg::out_t              out_data_i,
  input  logic                        cfg_valid_i,
  input  logic                        cfg_ready_i,
  input  logic [fpff_pkg::SIZE_W-1:0] cfg_data_i,
  output int                          mismatch_count_o,
  output int                          results_due_o
);

  timeunit 1ns;
  timeprecision 1ps;

  import fpff_pkg::*;

  localparam logic [FRAG_W-1:0] FRAG_CEIL = '1;

  // Shadow copy of the partition table and totals.
  logic [SIZE_W-1:0] part_kb [MAX_PARTITIONS];
  logic              part_open [MAX_PARTITIONS];
  int                slots_taken;
  int                open_count;
  logic [SIZE_W-1:0] used_kb;
  logic [SIZE_W-1:0] total_kb;
  logic [FRAG_W-1:0] frag_kb;

  out_t results_due [$];
  out_t oldest;
  int   wrong_now;

  function automatic out_t first_fit_result(in_t item);
    out_t              res;
    logic [SIZE_W:0]   sum_kb;
    logic [FRAG_W:0]   frag_sum;
    logic              placed;
    res          = '0;
    placed       = 1'b0;
    if (item.opcode == OP_DEFINE) begin
      if (slots_taken >= MAX_PARTITIONS) begin
        res.status = ST_TABLE_FULL;
      end else begin
        res.slot = SLOT_OUT_W'(slots_taken);
        sum_kb   = {1'b0, used_kb} + {1'b0, item.item_size};
        if (sum_kb > {1'b0, total_kb}) begin
          // slot is consumed even though the partition does not fit
          part_open[slots_taken] = 1'b0;
          res.status = ST_REJECTED;
        end else begin
          part_kb[slots_taken]   = item.item_size;
          part_open[slots_taken] = 1'b1;
          used_kb                = sum_kb[SIZE_W-1:0];
          open_count++;
          res.status = ST_ACCEPTED;
        end
        slots_taken++;
      end
    end else if (open_count == 0) begin
      res.status = ST_NONE_LEFT;
    end else begin
      res.status = ST_NONE_FITS;
      for (int k = 0; k < slots_taken; k++) begin
        if (!placed && part_open[k] && part_kb[k] >= item.item_size) begin
          frag_sum = {1'b0, frag_kb} + (FRAG_W + 1)'(part_kb[k] - item.item_size);
          frag_kb  = (frag_sum > {1'b0, FRAG_CEIL}) ? FRAG_CEIL : frag_sum[FRAG_W-1:0];
          part_open[k] = 1'b0;
          open_count--;
          res.slot   = SLOT_OUT_W'(k);
          res.status = ST_PLACED;
          placed     = 1'b1;
        end
      end
    end
    res.space_left    = (used_kb > total_kb) ? '0 : total_kb - used_kb;
    res.fragmentation = frag_kb;
    return res;
  endfunction

  function automatic int count_wrong_fields(out_t want, out_t got);
    int n;
    n = 0;
    if (got.status !== want.status) begin
      $display("%0t ns: status expected %0d, actual %0d", $time, want.status, got.status);
      n++;
    end
    if (got.slot !== want.slot) begin
      $display("%0t ns: slot expected %0d, actual %0d", $time, want.slot, got.slot);
      n++;
    end
    if (got.space_left !== want.space_left) begin
      $display("%0t ns: space_left expected %0d, actual %0d", $time, want.space_left,
               got.space_left);
      n++;
    end
    if (got.fragmentation !== want.fragmentation) begin
      $display("%0t ns: fragmentation expected %0d, actual %0d", $time,
               want.fragmentation, got.fragmentation);
      n++;
    end
    return n;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MAX_PARTITIONS; k++) begin
        part_kb[k]   = '0;
        part_open[k] = 1'b0;
      end
      slots_taken = 0;
      open_count  = 0;
      used_kb     = '0;
      total_kb    = '0;
      frag_kb     = '0;
      results_due.delete();
      mismatch_count_o <= 0;
      results_due_o    <= 0;
    end else begin
      wrong_now = 0;
      if (cfg_valid_i && cfg_ready_i) begin
        total_kb = cfg_data_i;
      end
      // check the result beat before predicting the one that enters now
      if (out_valid_i && !out_stall_i) begin
        if (results_due.size() == 0) begin
          $display("%0t ns: result with none expected, actual status %0d slot %0d", $time,
                   out_data_i.status, out_data_i.slot);
          wrong_now++;
        end else begin
          oldest    = results_due.pop_front();
          wrong_now += count_wrong_fields(oldest, out_data_i);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        results_due.push_back(first_fit_result(in_data_i));
      end
      mismatch_count_o <= mismatch_count_o + wrong_now;
      results_due_o    <= results_due.size();
    end
  end

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the fixed-partition first-fit allocator: directed defines and
// allocations around the size limits, then random phases under several total
// sizes with random input gaps and result stalls. Checking is in fpff_checker.
// ----------------------------------------------------------------------------
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  import fpff_pkg::*;

  localparam int KB_MAX        = (1 << SIZE_W) - 1;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_ITEMS   = 250;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int DRAIN_CYCLES  = 24;

  logic              clk_i     = 1'b0;
  logic              rst_ni    = 1'b0;
  logic              in_valid  = 1'b0;
  in_t               in_data   = '0;
  logic              in_stall;
  logic              out_valid;
  logic              out_stall;
  out_t              out_data;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [SIZE_W-1:0] cfg_data  = '0;

  int   mismatch_count;
  int   results_due;
  int   result_hold = 0;
  int   cycle_count = 0;
  logic steady      = 1'b0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  fixed_partition_first_fit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  fpff_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .in_data_i        (in_data),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .out_data_i       (out_data),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_data_i       (cfg_data),
    .mismatch_count_o (mismatch_count),
    .results_due_o    (results_due)
  );

  // Draw a fresh stall for each result beat taken.
  always @(posedge clk_i) begin
    if (result_hold != 0) begin
      result_hold <= result_hold - 1;
    end else if (out_valid && !out_stall) begin
      result_hold <= steady ? 0 : $urandom_range(0, 12);
    end
  end
  assign out_stall = (result_hold != 0);

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_item(input logic op, input logic [SIZE_W-1:0] kb);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= '{opcode: op, item_size: kb};
    do @(posedge clk_i); while (in_stall);
  endtask

  // Drop valid and hold until every result beat has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (results_due != 0) @(posedge clk_i);
  endtask

  task automatic write_total(input logic [SIZE_W-1:0] kb);
    cfg_valid <= 1'b1;
    cfg_data  <= kb;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [SIZE_W-1:0] pick_kb(int common_max);
    if ($urandom_range(0, 3) == 0) return SIZE_W'($urandom_range(0, KB_MAX));
    return SIZE_W'($urandom_range(0, common_max));
  endfunction

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Zero total: allocate on an empty table, zero-sized partition and process.
    write_total('0);
    send_item(OP_ALLOC, '0);
    send_item(OP_DEFINE, '0);
    send_item(OP_DEFINE, SIZE_W'(1));
    send_item(OP_ALLOC, SIZE_W'(1));
    send_item(OP_ALLOC, '0);
    send_item(OP_ALLOC, '0);
    drain_results();

    // Full total: a define that would overflow the size sum, largest request.
    write_total(SIZE_W'(KB_MAX));
    send_item(OP_DEFINE, SIZE_W'(600000));
    send_item(OP_DEFINE, SIZE_W'(500000));
    send_item(OP_ALLOC, SIZE_W'(KB_MAX));
    send_item(OP_ALLOC, '0);
    drain_results();

    // Shrink the total below what is already used.
    write_total(SIZE_W'(1000));
    send_item(OP_DEFINE, '0);
    send_item(OP_DEFINE, SIZE_W'(7));
    send_item(OP_ALLOC, SIZE_W'(KB_MAX));
    drain_results();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase != 0) drain_results();
      case (phase)
        0:                 write_total(SIZE_W'(KB_MAX));
        RANDOM_PHASES - 1: write_total('0);
        default: begin
          if ($urandom_range(0, 3) == 0) write_total(SIZE_W'($urandom_range(0, KB_MAX)));
          else write_total(SIZE_W'($urandom_range(600000, KB_MAX)));
        end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 50 == 0) steady = ($urandom_range(0, 3) == 0);
        // keep defines rare so the table fills slowly
        if ($urandom_range(0, 39) == 0) send_item(OP_DEFINE, pick_kb(80000));
        else send_item(OP_ALLOC, pick_kb(90000));
      end
    end

    steady = 1'b0;
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && results_due == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
